>>> src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Request and result beats, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int MW = 2 * DATA_WIDTH;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_res;

    // Control toward the shared divider.
    typedef struct packed {
        logic start;
    } t_div_ctl;
endpackage
`default_nettype wire

>>> src/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: fraction add/sub/mul/div/compare with gcd
// An error goes straight to the result strobe; compare ends once both products
// are combined; a zero numerator goes out as 0/1 without the gcd; otherwise the
// result waits for the Euclid steps and the reduction divides, all on the single
// 64-bit bit-serial divider. Only one request is in flight: busy drops in the
// strobe cycle, when the next request may be accepted. Reset (synchronous,
// active low) idles the FSM.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rau_pkg::t_req i_req,
    output logic               o_valid,
    output rau_pkg::t_res      o_res
);
    localparam int W  = rau_pkg::DATA_WIDTH;
    localparam int MW = rau_pkg::MW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_COMB = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_GW   = 4'd7;
    localparam logic [3:0] S_RN   = 4'd8;
    localparam logic [3:0] S_RNW  = 4'd9;
    localparam logic [3:0] S_RDW  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_NST  = 4'd12;

    logic [3:0]    r_st;
    logic [2:0]    r_op;
    logic [W-1:0]  r_anm, r_adm, r_bnm, r_bdm;
    logic          r_ans, r_bns, r_err;
    logic [MW-1:0] r_p, r_q, r_dd;
    logic          r_ps, r_qs;
    logic [MW-1:0] r_nm, r_ga, r_gb;
    logic          r_nneg;
    logic [MW-1:0] r_mx, r_my;
    logic [MW-1:0] r_prod;
    logic [1:0]    r_mi;
    logic [MW-1:0] r_nred;
    rau_pkg::t_div_ctl w_dctl;
    logic [MW-1:0] w_dvd, w_dvs, w_quo, w_rem;
    logic          w_ddone;
    rau_pkg::t_res w_out;

    // Magnitude and sign of a low-W-bit field; -2^(W-1) gives 2^(W-1).
    function automatic logic [W:0] mag_of(input logic [31:0] v);
        logic [W-1:0] x;
        logic [W-1:0] m;
        x = v[W-1:0];
        m = x[W-1] ? (~x + 1'b1) : x;
        return {x[W-1] && (x != '0), m};
    endfunction

    logic [W:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = mag_of(i_req.a_num);
    assign w_ad = mag_of(i_req.a_den);
    assign w_bn = mag_of(i_req.b_num);
    assign w_bd = mag_of(i_req.b_den);

    assign busy = (r_st != S_IDLE);

    rau_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_dctl),
        .i_dvd  (w_dvd),
        .i_dvs  (w_dvs),
        .o_done (w_ddone),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    // Divider sharing: Euclid steps, then numerator and denominator reduction.
    // Chain the denominator divide onto the done beat of the numerator divide.
    always_comb begin
        w_dctl.start = 1'b0;
        w_dvd = r_ga;
        w_dvs = r_gb;
        unique case (r_st)
            S_GCD: w_dctl.start = 1'b1;
            S_NST: begin w_dctl.start = 1'b1; w_dvd = r_nm; w_dvs = r_ga; end
            S_RNW: begin w_dctl.start = w_ddone; w_dvd = r_dd; w_dvs = r_ga; end
            default: ;
        endcase
    end

    logic [MW:0] w_diff;
    logic [W:0]  w_lim;
    assign w_diff = {1'b0, r_p} - {1'b0, r_q};
    assign w_lim  = (W+1)'(1) << (W - 1);

    // Result beat as it leaves from S_OUT.
    always_comb begin
        w_out = '0;
        if (r_err) w_out.status = rau_pkg::ST_ZERO;
        else if (r_op == rau_pkg::OP_CMP) begin
            w_out.res_den = 31'd1;
            w_out.order   = (r_nm == '0) ? rau_pkg::ORD_EQ
                          : (r_nneg ? rau_pkg::ORD_LT : rau_pkg::ORD_GT);
        end else if (r_dd > MW'(w_lim - 1'b1)
                  || (r_nneg ? r_nred > MW'(w_lim) : r_nred > MW'(w_lim - 1'b1)))
            w_out.status = rau_pkg::ST_OVF;
        else begin
            w_out.res_num = r_nneg ? 32'(-r_nred) : 32'(r_nred);
            w_out.res_den = 31'(r_dd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (start) begin
                    r_op  <= i_req.req_type;
                    // fold denominator signs onto numerators; negate b for
                    // subtract and compare so both work on a - b
                    r_anm <= w_an[W-1:0]; r_adm <= w_ad[W-1:0];
                    r_bnm <= w_bn[W-1:0]; r_bdm <= w_bd[W-1:0];
                    r_ans <= w_an[W] ^ w_ad[W];
                    r_bns <= w_bn[W] ^ w_bd[W] ^ ((i_req.req_type == rau_pkg::OP_SUB)
                                                || (i_req.req_type == rau_pkg::OP_CMP));
                    r_err <= (i_req.req_type > rau_pkg::OP_CMP) || (w_ad[W-1:0] == '0)
                          || (w_bd[W-1:0] == '0)
                          || ((i_req.req_type == rau_pkg::OP_DIV) && (w_bn[W-1:0] == '0));
                    r_st  <= S_LOAD;
                end
                S_LOAD: begin
                    // product p: an*bd (mul: an*bn)
                    r_mx <= MW'(r_anm);
                    r_my <= (r_op == rau_pkg::OP_MUL) ? MW'(r_bnm) : MW'(r_bdm);
                    r_mi <= 2'd0;
                    r_st <= r_err ? S_OUT : S_M1;
                end
                S_M1: begin
                    r_prod <= r_mx[W-1:0] * r_my[W-1:0];
                    r_st   <= S_M2;
                end
                S_M2: begin
                    // advance through the products (three for add/sub, two otherwise) on the one multiplier
                    unique case (r_mi)
                        2'd0: begin
                            r_p  <= r_prod;
                            r_mx <= (r_op == rau_pkg::OP_MUL) ? MW'(r_adm) : MW'(r_bnm);
                            r_my <= (r_op == rau_pkg::OP_MUL) ? MW'(r_bdm) : MW'(r_adm);
                        end
                        2'd1: begin
                            r_q <= r_prod;
                            r_mx <= MW'(r_adm); r_my <= MW'(r_bdm);
                        end
                        default: r_dd <= r_prod;
                    endcase
                    r_mi <= r_mi + 1'b1;
                    r_st <= (r_mi == 2'd2 || (r_mi == 2'd1 && r_op >= rau_pkg::OP_MUL))
                          ? S_M3 : S_M1;
                end
                S_M3: begin
                    r_ps <= (r_p != '0) && (r_op == rau_pkg::OP_MUL ? (r_ans ^ r_bns) : r_ans);
                    r_qs <= (r_q != '0) && r_bns;
                    if (r_op == rau_pkg::OP_MUL || r_op == rau_pkg::OP_DIV) r_dd <= r_q;
                    r_st <= S_COMB;
                end
                S_COMB: begin
                    if (r_op == rau_pkg::OP_CMP || r_op <= rau_pkg::OP_SUB) begin
                        if (r_ps == r_qs) begin
                            r_nm   <= r_p + r_q;
                            r_nneg <= r_ps;
                        end else if (w_diff[MW]) begin
                            r_nm   <= r_q - r_p;
                            r_nneg <= r_qs;
                        end else begin
                            r_nm   <= w_diff[MW-1:0];
                            r_nneg <= r_ps;
                        end
                    end else begin
                        r_nm   <= r_p;
                        r_nneg <= (r_p != '0) && (r_ans ^ r_bns);
                    end
                    r_st <= (r_op == rau_pkg::OP_CMP) ? S_OUT : S_RN;
                end
                S_RN: begin
                    // prime Euclid with (d, n); a zero numerator goes out as 0/1
                    r_ga <= r_dd;
                    r_gb <= r_nm;
                    if (r_nm == '0) begin
                        r_nred <= '0;
                        r_dd   <= MW'(1);
                        r_st   <= S_OUT;
                    end else begin
                        r_st <= S_GCD;
                    end
                end
                S_GCD: r_st <= S_GW;
                S_GW: if (w_ddone) begin
                    r_ga <= r_gb;
                    r_gb <= w_rem;
                    r_st <= (w_rem == '0) ? S_NST : S_GCD;
                end
                S_NST: r_st <= S_RNW;
                S_RNW: if (w_ddone) begin
                    r_nred <= w_quo;
                    r_st   <= S_RDW;
                end
                S_RDW: if (w_ddone) begin
                    r_dd <= w_quo;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_res   <= w_out;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy during result");
    a_den_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == rau_pkg::ST_OK) |-> (o_res.res_den != '0))
        else $error("zero denominator with ok status");
endmodule
`default_nettype wire

>>> src/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: radix-2 restoring divider
// Unsigned MW-bit quotient and remainder, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire rau_pkg::t_div_ctl      i_ctl,
    input  wire logic [rau_pkg::MW-1:0] i_dvd,
    input  wire logic [rau_pkg::MW-1:0] i_dvs,
    output logic                        o_done,
    output logic [rau_pkg::MW-1:0]      o_quo,
    output logic [rau_pkg::MW-1:0]      o_rem
);
    localparam int CW = $clog2(rau_pkg::MW + 1);
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic [rau_pkg::MW-1:0] r_q, r_r, r_d;
    logic [rau_pkg::MW:0]   w_sh, w_df;

    assign w_sh = {r_r, r_q[rau_pkg::MW-1]};
    assign w_df = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(rau_pkg::MW);
                r_q    <= i_dvd;
                r_r    <= '0;
                r_d    <= i_dvs;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                if (!w_df[rau_pkg::MW]) begin
                    r_r <= w_df[rau_pkg::MW-1:0];
                    r_q <= {r_q[rau_pkg::MW-2:0], 1'b1};
                end else begin
                    r_r <= w_sh[rau_pkg::MW-1:0];
                    r_q <= {r_q[rau_pkg::MW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
    assign o_rem = r_r;
endmodule
`default_nettype wire

>>> tb/sv/rational_arithmetic_unit_core_tb.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb: self-checking bench for the fraction unit
// Drives directed and random fraction requests through the start/busy
// handshake in bursts with random gaps. An exact signed-magnitude predictor
// works out each expected beat on acceptance. A monitor checks every result
// strobe field by field against the oldest expected beat.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        rau_pkg::t_req req;
        bit   drain;    // wait for every outstanding result before sending
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rau_pkg::t_req i_req = '0;
    logic o_valid;
    rau_pkg::t_res o_res;

    t_beat pending_beats[$];
    rau_pkg::t_res expected_results[$];
    int    mismatch_count = 0;
    int    gap_left = 0;
    int    burst_left = 4;

    rational_arithmetic_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Split a DATA_WIDTH operand into sign and 64-bit magnitude.
    function automatic void split_operand(input logic [31:0] raw, output bit neg,
                                          output bit [63:0] mag);
        logic [rau_pkg::DATA_WIDTH-1:0] x;
        logic [rau_pkg::DATA_WIDTH-1:0] m;
        x = raw[rau_pkg::DATA_WIDTH-1:0];
        neg = x[rau_pkg::DATA_WIDTH-1];
        m = -x;
        mag = neg ? 64'(m) : 64'(x);
        if (mag == 0) neg = 1'b0;
    endfunction

    // Signed-magnitude sum of two products.
    function automatic void sum_terms(input bit xs, input bit [63:0] xm, input bit ys,
                                      input bit [63:0] ym, output bit rs,
                                      output bit [63:0] rm);
        if (xs == ys) begin
            rm = xm + ym; rs = xs;
        end else if (xm >= ym) begin
            rm = xm - ym; rs = xs;
        end else begin
            rm = ym - xm; rs = ys;
        end
        if (rm == 0) rs = 1'b0;
    endfunction

    // Exact fraction arithmetic with gcd reduction.
    function automatic rau_pkg::t_res predict_fraction(rau_pkg::t_req r);
        rau_pkg::t_res res;
        bit        ans, ads, bns, bds, ps, qs, ns, ds;
        bit [63:0] anm, adm, bnm, bdm, pm, qm, nm, dm, ga, gb, gt, lim;
        res = '0;
        split_operand(r.a_num, ans, anm);
        split_operand(r.a_den, ads, adm);
        split_operand(r.b_num, bns, bnm);
        split_operand(r.b_den, bds, bdm);
        if (r.req_type > rau_pkg::OP_CMP || adm == 0 || bdm == 0) begin
            res.status = rau_pkg::ST_ZERO;
            return res;
        end
        // move denominator signs onto the numerators
        if (ads) begin ads = 0; ans = (anm != 0) && !ans; end
        if (bds) begin bds = 0; bns = (bnm != 0) && !bns; end
        if (r.req_type == rau_pkg::OP_SUB) bns = (bnm != 0) && !bns;
        pm = anm * bdm; ps = (pm != 0) && ans;
        qm = bnm * adm; qs = (qm != 0) && bns;
        if (r.req_type == rau_pkg::OP_CMP) begin
            res.res_den = 31'd1;
            if (ps != qs) res.order = ps ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
            else if (pm == qm) res.order = rau_pkg::ORD_EQ;
            else if (ps) res.order = (pm > qm) ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
            else res.order = (pm > qm) ? rau_pkg::ORD_GT : rau_pkg::ORD_LT;
            return res;
        end
        if (r.req_type == rau_pkg::OP_ADD || r.req_type == rau_pkg::OP_SUB) begin
            sum_terms(ps, pm, qs, qm, ns, nm);
            dm = adm * bdm;
        end else if (r.req_type == rau_pkg::OP_MUL) begin
            nm = anm * bnm; ns = (nm != 0) && (ans != bns);
            dm = adm * bdm;
        end else begin
            if (bnm == 0) begin
                res.status = rau_pkg::ST_ZERO;
                return res;
            end
            nm = pm; dm = adm * bnm;
            ns = (nm != 0) && (ans != bns);
        end
        ga = nm; gb = dm;
        while (gb != 0) begin
            gt = ga % gb; ga = gb; gb = gt;
        end
        nm = nm / ga; dm = dm / ga;
        lim = 64'd1 << (rau_pkg::DATA_WIDTH - 1);
        if (dm > lim - 1 || (ns ? nm > lim : nm > lim - 1)) begin
            res.status = rau_pkg::ST_OVF;
            return res;
        end
        res.res_num = ns ? 32'(-nm) : 32'(nm);
        res.res_den = 31'(dm);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Driver: hold start with the head beat until accepted, gap between bursts.
    always @(posedge i_clk) begin
        logic accepted;
        accepted = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (accepted) begin
                expected_results.push_back(predict_fraction(i_req));
                pending_beats.delete(0);
                if (burst_left > 0) burst_left--;
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_beats.size() == 0) begin
                start <= 1'b0;
            end else if (pending_beats[0].drain && expected_results.size() != 0) begin
                start <= 1'b0;
            end else if (accepted && burst_left == 0) begin
                // close the burst; some bursts run back to back
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_req <= pending_beats[0].req;
            end
        end
    end

    // Monitor: every strobe must match the oldest expected beat.
    always @(posedge i_clk) begin
        rau_pkg::t_res want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t result beat with nothing expected", $realtime);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_res.res_num !== want.res_num)
                    report_mismatch("res_num", o_res.res_num, want.res_num);
                if (o_res.res_den !== want.res_den)
                    report_mismatch("res_den", 32'(o_res.res_den), 32'(want.res_den));
                if (o_res.order !== want.order)
                    report_mismatch("order", 32'(o_res.order), 32'(want.order));
                if (o_res.status !== want.status)
                    report_mismatch("status", 32'(o_res.status), 32'(want.status));
            end
        end
    end

    task automatic queue_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd, bit drain = 0);
        t_beat b;
        b.req = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        b.drain = drain;
        pending_beats.push_back(b);
    endtask

    // Mostly small operands keep Euclid short; some full-width and edge values.
    function automatic logic [31:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 32'($signed($urandom_range(0, 2000)) - 1000);
        if (sel < 88) return $urandom;
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd1;
            4: return 32'h8000_0001;
            default: return 32'd0;
        endcase
    endfunction

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;

    initial begin
        logic [2:0] op;
        // directed: each operation, sign moves, zero cases, extremes
        queue_beat(rau_pkg::OP_ADD, 1, 2, 1, 3);
        queue_beat(rau_pkg::OP_SUB, 1, 2, 1, 2);           // zero result as 0/1
        queue_beat(rau_pkg::OP_MUL, 3, -4, -2, 9);         // negative denominator
        queue_beat(rau_pkg::OP_DIV, -5, 6, 10, -3);
        queue_beat(rau_pkg::OP_CMP, 1, 3, 1, 2);
        queue_beat(rau_pkg::OP_CMP, 2, 4, -1, -2);
        queue_beat(rau_pkg::OP_CMP, -1, 3, -1, 2);
        queue_beat(rau_pkg::OP_ADD, 1, 0, 1, 1);           // zero denominator in a
        queue_beat(rau_pkg::OP_CMP, 1, 1, 1, 0);           // zero denominator in b
        queue_beat(rau_pkg::OP_DIV, 1, 2, 0, 5);           // divide by zero fraction
        queue_beat(3'd5, 1, 1, 1, 1);                      // unknown codes
        queue_beat(3'd6, 0, 0, 0, 0);
        queue_beat(3'd7, MAXP, MAXP, MAXP, MAXP);
        queue_beat(rau_pkg::OP_MUL, MAXP, 1, 2, 1);        // numerator overflow
        queue_beat(rau_pkg::OP_MUL, 1, MAXP, 1, 2);        // denominator overflow
        queue_beat(rau_pkg::OP_MUL, MINN, 1, 1, 1);        // most negative fits
        queue_beat(rau_pkg::OP_MUL, MINN, -1, 1, 1);
        queue_beat(rau_pkg::OP_ADD, MINN, MINN, MINN, MINN);
        queue_beat(rau_pkg::OP_SUB, MAXP, MINN, MINN, MAXP);
        queue_beat(rau_pkg::OP_DIV, MINN, MAXP, MAXP, MINN);
        queue_beat(rau_pkg::OP_CMP, MINN, MAXP, MAXP, MINN);
        queue_beat(rau_pkg::OP_ADD, 0, -7, 0, 3);
        for (int k = 0; k < 550; k++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            queue_beat(op, pick_operand(), pick_operand(), pick_operand(),
                       pick_operand(), (k % 90) == 45);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_beats.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog sized for the slowest Euclid path on every request.
    initial begin
        #300ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
